// ===== src/strict_priority_ready_queue_scheduler_top_assert.svh =====
// Assertion macros for the strict-priority scheduler.
// Used by the top level; depends on signals named clk and rst_n in scope.
`ifndef STRICT_PRIORITY_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define STRICT_PRIORITY_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq: assertion failed");
// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq: assertion failed");
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons)
`define SPQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/spq_pkg.sv =====
// Shared types and constants for the strict-priority scheduler.
// No dependencies.
package spq_pkg;

  localparam int NUM_PRI_DEF     = 8;
  localparam int NUM_THREADS_DEF = 16;

  localparam int TID_W    = 4;
  localparam int STATUS_W = 2;
  localparam int TS_W     = 3;

  // item kinds (in_tuser)
  localparam logic [1:0] KIND_SET_READY = 2'd0;
  localparam logic [1:0] KIND_SCHEDULE  = 2'd1;
  localparam logic [1:0] KIND_SUSPEND   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] RES_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] RES_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] RES_NOT_RDY = 2'd2;
  localparam logic [STATUS_W-1:0] RES_IDLE    = 2'd3;

  // thread status codes; 0..3 are wait states
  localparam logic [TS_W-1:0] TS_NEW   = 3'd4;
  localparam logic [TS_W-1:0] TS_READY = 3'd5;
  localparam logic [TS_W-1:0] TS_RUN   = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SR_CHK,
    S_SP_CHK,
    S_SC_RQ,
    S_SC_SCAN,
    S_SC_POP,
    S_RESP
  } state_t;

  function automatic logic ts_active(input logic [TS_W-1:0] s);
    return (s == TS_READY) || (s == TS_RUN);
  endfunction

endpackage

// ===== src/strict_priority_ready_queue_scheduler_top.sv =====
// Strict-priority ready-queue scheduler. One item is handled at a time; every item
// gives one result. An unused kind and an item refused at once (suspend with no
// current thread, thread id out of range) go straight to the response state;
// set_ready and any other suspend first read the thread status RAM; schedule
// first reads the status of the current thread when one exists, then scans the
// queues from index 0 upward and takes the head of the lowest non-empty queue; a
// schedule that finds every queue empty reports idle. The result waits on the
// registered reads of the thread status RAM and the queue RAM and on the queue scan,
// which looks at one priority level per cycle. The block takes the next item once the
// result moves into the output register. A result waiting in the output register does
// not block the next item from being accepted, but that item's result waits for it.
// Depends on spq_pkg, spq_ram and the assertion header.
`include "strict_priority_ready_queue_scheduler_top_assert.svh"

module strict_priority_ready_queue_scheduler_top
  import spq_pkg::*;
#(
  parameter int NUM_PRI     = NUM_PRI_DEF,
  parameter int NUM_THREADS = NUM_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // thread_id[3:0], priority_req[6:4], wait_state[8:7]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], next_thread[5:2], next_valid[6]
);

  localparam int PW     = $clog2(NUM_PRI);
  localparam int TW     = $clog2(NUM_THREADS);
  localparam int CW     = $clog2(NUM_THREADS + 1);
  localparam int QAW    = PW + TW;
  localparam int QDEPTH = NUM_PRI * (2 ** TW);

  // input unpack
  logic [3:0]    in_tid;
  logic [2:0]    in_pri;
  logic [1:0]    in_ws;
  logic          in_acc;
  logic          tid_ok;
  logic [PW-1:0] pri_sat;

  assign in_tid  = in_tdata[3:0];
  assign in_pri  = in_tdata[6:4];
  assign in_ws   = in_tdata[8:7];
  assign in_acc  = in_tvalid && in_tready;
  assign tid_ok  = int'(in_tid) < NUM_THREADS;
  assign pri_sat = (int'(in_pri) >= NUM_PRI) ? PW'(NUM_PRI - 1) : PW'(in_pri);

  state_t state_r, state_nxt;

  logic [TW-1:0]       tid_r;
  logic [PW-1:0]       pri_r;
  logic [1:0]          ws_r;
  logic [TW-1:0]       cur_r;
  logic                cur_vld_r;
  logic [PW-1:0]       scan_r;
  logic [TW-1:0]       head_r [NUM_PRI];
  logic [TW-1:0]       tail_r [NUM_PRI];
  logic [CW-1:0]       cnt_r  [NUM_PRI];
  logic [NUM_THREADS-1:0] ts_vld_r;
  logic                rd_vld_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [TW-1:0]       res_tid_r;
  logic                res_nv_r;
  logic                out_tvalid_r;
  logic [7:0]          out_tdata_r;

  // control strobes
  logic                ts_re, ts_we, pr_we;
  logic [TW-1:0]       ts_raddr, ts_waddr;
  logic [TS_W-1:0]     ts_wdata, ts_rdata, sts_rd;
  logic [PW-1:0]       pr_rdata;
  logic                push_req, push_en, push_full, pop_en, q_re;
  logic [PW-1:0]       push_pri;
  logic [TW-1:0]       push_tid, q_rdata;
  logic                res_ld, cur_ld, scan_clr, scan_inc, out_ld;
  logic [STATUS_W-1:0] res_status_nxt;
  logic [TW-1:0]       res_tid_nxt;
  logic                res_nv_nxt;

  assign sts_rd    = rd_vld_r ? ts_rdata : TS_NEW;
  assign push_full = cnt_r[push_pri] == CW'(NUM_THREADS);
  assign push_en   = push_req && !push_full;

  spq_ram #(.WIDTH(TS_W), .DEPTH(NUM_THREADS)) u_status_ram (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .re    (ts_re),
    .raddr (ts_raddr),
    .rdata (ts_rdata)
  );

  spq_ram #(.WIDTH(PW), .DEPTH(NUM_THREADS)) u_prio_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (tid_r),
    .wdata (pri_r),
    .re    (ts_re),
    .raddr (ts_raddr),
    .rdata (pr_rdata)
  );

  spq_ram #(.WIDTH(TW), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (push_en),
    .waddr ({push_pri, tail_r[push_pri]}),
    .wdata (push_tid),
    .re    (q_re),
    .raddr (QAW'({scan_r, head_r[scan_r]})),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    ts_re          = 1'b0;
    ts_raddr       = cur_r;
    ts_we          = 1'b0;
    ts_waddr       = cur_r;
    ts_wdata       = TS_READY;
    pr_we          = 1'b0;
    push_req       = 1'b0;
    push_pri       = pri_r;
    push_tid       = tid_r;
    pop_en         = 1'b0;
    q_re           = 1'b0;
    res_ld         = 1'b0;
    res_status_nxt = RES_OK;
    res_tid_nxt    = '0;
    res_nv_nxt     = 1'b0;
    cur_ld         = 1'b0;
    scan_clr       = 1'b0;
    scan_inc       = 1'b0;
    out_ld         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          case (in_tuser)
            KIND_SET_READY: begin
              if (tid_ok) begin
                ts_re     = 1'b1;
                ts_raddr  = TW'(in_tid);
                state_nxt = S_SR_CHK;
              end else begin
                res_ld         = 1'b1;
                res_status_nxt = RES_NOT_RDY;
                state_nxt      = S_RESP;
              end
            end
            KIND_SUSPEND: begin
              if (cur_vld_r) begin
                ts_re     = 1'b1;
                state_nxt = S_SP_CHK;
              end else begin
                res_ld         = 1'b1;
                res_status_nxt = RES_NOT_RDY;
                state_nxt      = S_RESP;
              end
            end
            KIND_SCHEDULE: begin
              scan_clr = 1'b1;
              if (cur_vld_r) begin
                ts_re     = 1'b1;
                state_nxt = S_SC_RQ;
              end else begin
                state_nxt = S_SC_SCAN;
              end
            end
            default: begin
              res_ld    = 1'b1;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SR_CHK: begin
        res_ld = 1'b1;
        if (ts_active(sts_rd)) begin
          res_status_nxt = RES_DUP;
        end else begin
          ts_we    = 1'b1;
          ts_waddr = tid_r;
          pr_we    = 1'b1;
          push_req = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_SP_CHK: begin
        res_ld = 1'b1;
        if (ts_active(sts_rd)) begin
          ts_we    = 1'b1;
          ts_wdata = TS_W'(ws_r);
        end else begin
          res_status_nxt = RES_NOT_RDY;
        end
        state_nxt = S_RESP;
      end
      S_SC_RQ: begin
        // running or ready current thread goes back to the tail of its queue, if it is not full
        if (ts_active(sts_rd)) begin
          ts_we    = 1'b1;
          push_req = 1'b1;
          push_pri = pr_rdata;
          push_tid = cur_r;
        end
        state_nxt = S_SC_SCAN;
      end
      S_SC_SCAN: begin
        if (cnt_r[scan_r] != '0) begin
          pop_en    = 1'b1;
          q_re      = 1'b1;
          state_nxt = S_SC_POP;
        end else if (scan_r == PW'(NUM_PRI - 1)) begin
          res_ld         = 1'b1;
          res_status_nxt = RES_IDLE;
          state_nxt      = S_RESP;
        end else begin
          scan_inc = 1'b1;
        end
      end
      S_SC_POP: begin
        ts_we       = 1'b1;
        ts_waddr    = q_rdata;
        ts_wdata    = TS_RUN;
        cur_ld      = 1'b1;
        res_ld      = 1'b1;
        res_tid_nxt = q_rdata;
        res_nv_nxt  = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // item fields and read-side bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tid_r <= TW'(in_tid);
      pri_r <= pri_sat;
      ws_r  <= in_ws;
    end
    if (ts_re) begin
      rd_vld_r <= ts_vld_r[ts_raddr];
    end
    if (res_ld) begin
      res_status_r <= res_status_nxt;
      res_tid_r    <= res_tid_nxt;
      res_nv_r     <= res_nv_nxt;
    end
    if (out_ld) begin
      out_tdata_r <= {1'b0, res_nv_r, TID_W'(res_tid_r), res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      cur_vld_r    <= 1'b0;
      scan_r       <= '0;
      ts_vld_r     <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_PRI; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cur_ld) begin
        cur_r     <= q_rdata;
        cur_vld_r <= 1'b1;
      end
      if (scan_clr) begin
        scan_r <= '0;
      end else if (scan_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      if (ts_we) begin
        ts_vld_r[ts_waddr] <= 1'b1;
      end
      if (out_ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      // push and pop never fall in the same cycle
      if (push_en) begin
        tail_r[push_pri] <= (tail_r[push_pri] == TW'(NUM_THREADS - 1)) ? '0
                          : tail_r[push_pri] + 1'b1;
        cnt_r[push_pri]  <= cnt_r[push_pri] + 1'b1;
      end
      if (pop_en) begin
        head_r[scan_r] <= (head_r[scan_r] == TW'(NUM_THREADS - 1)) ? '0
                        : head_r[scan_r] + 1'b1;
        cnt_r[scan_r]  <= cnt_r[scan_r] - 1'b1;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `SPQ_ASSERT_IMP(a_nv_ok, out_tvalid && out_tdata[6], out_tdata[1:0] == RES_OK)
  `SPQ_ASSERT_IMP(a_nv_zero, out_tvalid && !out_tdata[6], out_tdata[5:2] == 4'd0)
  `SPQ_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready)
  `SPQ_ASSERT_IMP(a_cur_run, state_r == S_RESP && res_nv_r, cur_vld_r && cur_r == res_tid_r)

endmodule

// ===== src/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/spq_checker.sv =====
// Checker for the strict-priority scheduler: tracks the ready queues and thread
// states from the accepted items and compares every result in order.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_checker
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // thread_id[3:0], priority_req[6:4], wait_state[8:7]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // status[1:0], next_thread[5:2], next_valid[6]
  output int          fail_count,
  output int          pending
);

  localparam int NPRI = NUM_PRI_DEF;
  localparam int NTHR = NUM_THREADS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    thread;
    logic                granted;
  } outcome_t;

  // shadow of the scheduler state
  logic [TID_W-1:0] rq_slot  [NPRI][NTHR];
  logic [TID_W-1:0] rq_head  [NPRI];
  logic [TID_W-1:0] rq_tail  [NPRI];
  logic [4:0]       rq_count [NPRI];
  logic [TS_W-1:0]  th_state [NTHR];
  logic [2:0]       th_pri   [NTHR];
  logic [TID_W-1:0] cur_th;
  logic             cur_live;

  outcome_t awaited_outcomes[$];
  int       errs = 0;
  int       seen = 0;

  function automatic void rq_push(input int p, input logic [TID_W-1:0] th);
    // a full queue silently drops the push
    if (rq_count[p] >= NTHR) return;
    rq_slot[p][rq_tail[p]] = th;
    rq_tail[p]  = TID_W'((rq_tail[p] + 1) % NTHR);
    rq_count[p] = rq_count[p] + 1'b1;
  endfunction

  function automatic outcome_t dispatch_outcome(input logic [1:0] kind,
                                                input logic [TID_W-1:0] tid,
                                                input logic [2:0] pri,
                                                input logic [1:0] ws);
    outcome_t         r;
    logic [TID_W-1:0] nt;
    logic [2:0]       pp;
    int               p;
    r = '0;
    case (kind)
      KIND_SET_READY: begin
        if (tid >= NTHR) begin
          r.status = RES_NOT_RDY;
        end else if (th_state[tid] == TS_READY || th_state[tid] == TS_RUN) begin
          r.status = RES_DUP;
        end else begin
          pp = (pri >= NPRI) ? 3'(NPRI - 1) : pri;
          th_pri[tid]   = pp;
          th_state[tid] = TS_READY;
          rq_push(int'(pp), tid);
        end
      end
      KIND_SUSPEND: begin
        if (!cur_live || (th_state[cur_th] != TS_READY && th_state[cur_th] != TS_RUN)) begin
          r.status = RES_NOT_RDY;
        end else begin
          th_state[cur_th] = {1'b0, ws};
        end
      end
      KIND_SCHEDULE: begin
        // requeue even a thread that was suspended and then made ready again
        if (cur_live && (th_state[cur_th] == TS_READY || th_state[cur_th] == TS_RUN)) begin
          th_state[cur_th] = TS_READY;
          rq_push(int'(th_pri[cur_th]), cur_th);
        end
        r.status = RES_IDLE;
        for (p = 0; p < NPRI; p++) begin
          if (rq_count[p] != 0) begin
            nt = rq_slot[p][rq_head[p]];
            rq_head[p]  = TID_W'((rq_head[p] + 1) % NTHR);
            rq_count[p] = rq_count[p] - 1'b1;
            th_state[nt] = TS_RUN;
            cur_th   = nt;
            cur_live = 1'b1;
            r.status  = RES_OK;
            r.thread  = nt;
            r.granted = 1'b1;
            return r;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    int       i;
    if (!rst_n) begin
      for (i = 0; i < NPRI; i++) begin
        rq_head[i]  = '0;
        rq_tail[i]  = '0;
        rq_count[i] = '0;
      end
      for (i = 0; i < NTHR; i++) begin
        th_state[i] = TS_NEW;
        th_pri[i]   = '0;
      end
      cur_th   = '0;
      cur_live = 1'b0;
      awaited_outcomes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status  = out_tdata[1:0];
        got.thread  = out_tdata[5:2];
        got.granted = out_tdata[6];
        if (awaited_outcomes.size() == 0) begin
          if (errs < 10)
            $display("spq_checker: result %0d (%h) arrived with nothing expected",
                     seen, out_tdata);
          errs++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.status != want.status || got.thread != want.thread ||
              got.granted != want.granted) begin
            if (errs < 10)
              $display({"spq_checker: result %0d exp status %0d thread %0d valid %0d,",
                        " got %0d %0d %0d"},
                       seen, want.status, want.thread, want.granted,
                       got.status, got.thread, got.granted);
            errs++;
          end
        end
        seen++;
      end
      if (in_tvalid && in_tready)
        awaited_outcomes.push_back(dispatch_outcome(in_tuser, in_tdata[3:0],
                                                    in_tdata[6:4], in_tdata[8:7]));
    end
    fail_count <= errs;
    pending    <= awaited_outcomes.size();
  end

endmodule

// ===== dv/strict_priority_ready_queue_scheduler_top_test.sv =====
// Testbench top for the strict-priority scheduler: clock, reset, item stimulus,
// receiver stalls, watchdog and verdict. Depends on spq_pkg, the scheduler RTL
// and spq_checker.
`timescale 1ns / 1ps

module strict_priority_ready_queue_scheduler_top_test;
  import spq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         ITEM_GOAL   = 1450;
  localparam int         STALL_LIMIT = 3000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  int               fail_count;
  int               pending;
  int               sent       = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  logic [TID_W-1:0] latest_dispatch = '0;

  strict_priority_ready_queue_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  spq_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // last thread handed out, used to steer the queue pile-up sequence
  always @(posedge clk) begin
    if (out_tvalid && out_tready && out_tdata[6])
      latest_dispatch <= out_tdata[5:2];
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall patterns, plus one long hold-off to back up the block
  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sent >= 700) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 150);
      repeat (len) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [TID_W-1:0] rnd_tid();
    return TID_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [2:0] rnd_pri();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [1:0] rnd_ws();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic send(input logic [1:0] kind, input logic [TID_W-1:0] tid,
                      input logic [2:0] pri, input logic [1:0] ws);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, ws, pri, tid};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // bursts of random length separated by random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // repeatedly suspend and re-ready the running thread at priority 0 so that
  // duplicates build up until the queue overflows
  task automatic pile_up();
    logic [TID_W-1:0] th;
    int               n;
    th = rnd_tid();
    send(KIND_SET_READY, th, 3'd0, rnd_ws());
    send(KIND_SCHEDULE, rnd_tid(), rnd_pri(), rnd_ws());
    settle();
    for (n = 0; n < 20; n++) begin
      send(KIND_SUSPEND, rnd_tid(), rnd_pri(), rnd_ws());
      send(KIND_SET_READY, latest_dispatch, 3'd0, rnd_ws());
      send(KIND_SCHEDULE, rnd_tid(), rnd_pri(), rnd_ws());
      settle();
    end
  endtask

  initial begin
    int  pick;
    int  n;
    int  i;
    bit  piled_early;
    bit  piled_late;
    piled_early = 1'b0;
    piled_late  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);   // nothing queued: idle
    pace();
    send(KIND_SUSPEND,   4'd9,  3'd5, 2'd1);   // no current thread
    pace();
    send(KIND_UNUSED,    4'd15, 3'd7, 2'd3);
    pace();
    send(KIND_SET_READY, 4'd15, 3'd7, 2'd3);
    pace();
    send(KIND_SET_READY, 4'd15, 3'd0, 2'd0);   // already ready
    pace();
    send(KIND_SET_READY, 4'd0,  3'd0, 2'd2);
    pace();
    send(KIND_SET_READY, 4'd5,  3'd3, 2'd1);
    pace();
    send(KIND_SCHEDULE,  4'd7,  3'd2, 2'd0);
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);
    pace();
    send(KIND_SUSPEND,   4'd0,  3'd0, 2'd3);
    pace();
    send(KIND_SET_READY, 4'd0,  3'd0, 2'd0);   // re-ready while still current
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);   // queues it a second time
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);
    pace();
    send(KIND_SUSPEND,   4'd3,  3'd6, 2'd0);
    pace();
    send(KIND_SUSPEND,   4'd0,  3'd0, 2'd1);   // current already waiting
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);
    pace();
    send(KIND_SUSPEND,   4'd0,  3'd0, 2'd1);
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);
    pace();
    send(KIND_SUSPEND,   4'd0,  3'd0, 2'd2);
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);
    pace();
    send(KIND_SUSPEND,   4'd0,  3'd0, 2'd3);
    pace();
    send(KIND_SCHEDULE,  4'd0,  3'd0, 2'd0);   // everything waiting: idle
    settle();

    while (sent < ITEM_GOAL) begin
      if (!piled_early && sent >= 300) begin
        piled_early = 1'b1;
        pile_up();
      end else if (!piled_late && sent >= 1000) begin
        piled_late = 1'b1;
        pile_up();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(0, 99);
        send((n < 40) ? KIND_SET_READY : (n < 75) ? KIND_SCHEDULE :
             (n < 95) ? KIND_SUSPEND : KIND_UNUSED,
             rnd_tid(), rnd_pri(), rnd_ws());
        pace();
      end else begin
        // a round: make a few threads ready, then run them, suspending some at random
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          send(KIND_SET_READY, rnd_tid(), rnd_pri(), rnd_ws());
          pace();
        end
        for (i = 0; i < n; i++) begin
          send(KIND_SCHEDULE, rnd_tid(), rnd_pri(), rnd_ws());
          pace();
          if ($urandom_range(0, 1)) begin
            send(KIND_SUSPEND, rnd_tid(), rnd_pri(), rnd_ws());
            pace();
          end
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/spq_pkg.sv
src/spq_ram.sv
src/strict_priority_ready_queue_scheduler_top.sv
dv/spq_checker.sv
dv/strict_priority_ready_queue_scheduler_top_test.sv
